// File: design/prs_pkg.sv
// shared types and constants for the packed record store
package prs_pkg;

  // command codes carried by the opcode field
  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  localparam logic [9:0] BASE_RESET = 10'd8;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  // register index of record_base on the configuration port
  localparam logic REG_RECORD_BASE = 1'b0;

  // one input transaction
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] word_index;
    logic [7:0] char_byte;
    logic       char_valid;
    logic       last_char;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  record_count;
    logic [10:0] bytes_used;
  } result_t;

  // micro-operations issued by the controller to the datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_WALK_INIT,
    CMD_WALK_RD,
    CMD_WALK_ADD,
    CMD_DECIDE,
    CMD_UP_RD,
    CMD_UP_WR,
    CMD_DN_RD,
    CMD_DN_WR,
    CMD_ZERO_INIT,
    CMD_ZERO_WR,
    CMD_PUT_LEN,
    CMD_PUT_RD,
    CMD_PUT_WR,
    CMD_BASE_WR,
    CMD_DONE
  } dp_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic clear_done;
    logic walk_done;
    logic up_done;
    logic dn_done;
    logic zero_done;
    logic put_done;
    logic need_up;
    logic need_dn;
    logic fail;
    op_t  op;
  } dp_stat_t;

endpackage

// File: design/prs_datapath.sv
// byte store, word buffer, address registers and checks of the record store
module prs_datapath #(
  parameter int STORE_BYTES    = 1024,
  parameter int MAX_WORD_CHARS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [9:0]         record_base,
  input  logic               start,
  input  logic               busy,
  input  prs_pkg::item_t     item,
  input  prs_pkg::dp_cmd_t   cmd,
  output prs_pkg::dp_stat_t  stat,
  output prs_pkg::result_t   result
);

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int PW   = $clog2(STORE_BYTES + 66048 + 2 * MAX_WORD_CHARS + 8);
  localparam int WL_W = $clog2(MAX_WORD_CHARS + 2);
  localparam int BW   = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
  localparam logic [PW-1:0]   STORE_END = PW'(STORE_BYTES);
  localparam logic [PW-1:0]   LAST_ADDR = PW'(STORE_BYTES - 1);
  localparam logic [WL_W-1:0] MAX_WL    = WL_W'(MAX_WORD_CHARS);

  logic [7:0] store [STORE_BYTES];
  logic [7:0] wbuf [MAX_WORD_CHARS];

  logic            we, re, buf_re, acc;
  logic [PW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata_raw, rdv, bdata;
  logic            rd_oob;

  logic [PW-1:0]   a, p_r, from_r, lim_r, mv;
  logic [7:0]      k, count_reg, pend_idx;
  logic [8:0]      s_r, d_r, n9;
  logic [WL_W-1:0] wl, i;
  prs_pkg::op_t    pend_op;
  prs_pkg::status_t status_r, code;
  logic            walk_done;

  assign acc       = start && !busy;
  assign n9        = 9'(wl) + 9'd1;
  assign rdv       = rd_oob ? 8'd0 : rdata_raw;
  assign walk_done = (k == count_reg);

  // command checks, in the order the command defines
  always_comb begin
    if (pend_op != prs_pkg::OP_APPEND && pend_idx >= count_reg) begin
      code = prs_pkg::ST_BAD_INDEX;
    end else if (pend_op == prs_pkg::OP_DELETE) begin
      code = prs_pkg::ST_OK;
    end else if (wl == '0) begin
      code = prs_pkg::ST_EMPTY;
    end else if (wl > MAX_WL) begin
      code = prs_pkg::ST_TOO_LONG;
    end else if (pend_op == prs_pkg::OP_REPLACE) begin
      code = (a - PW'(s_r) + PW'(n9) > STORE_END) ? prs_pkg::ST_NO_SPACE : prs_pkg::ST_OK;
    end else begin
      code = (count_reg == prs_pkg::COUNT_MAX || a + PW'(n9) > STORE_END) ?
             prs_pkg::ST_NO_SPACE : prs_pkg::ST_OK;
    end
  end

  // status back to the controller
  always_comb begin
    stat.clear_done = (mv == LAST_ADDR);
    stat.walk_done  = walk_done;
    stat.up_done    = (mv <= from_r);
    stat.dn_done    = (mv >= lim_r);
    stat.zero_done  = (mv >= lim_r);
    stat.put_done   = (i >= wl);
    stat.need_up    = (n9 > s_r);
    stat.need_dn    = (n9 < s_r);
    stat.fail       = (code != prs_pkg::ST_OK);
    stat.op         = pend_op;
  end

  // store port selection per micro-operation
  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    buf_re = 1'b0;
    waddr  = mv;
    raddr  = a;
    wdata  = 8'd0;
    case (cmd)
      prs_pkg::CMD_CLEAR: begin
        we = 1'b1;
      end
      prs_pkg::CMD_WALK_RD: begin
        re = !walk_done;
      end
      prs_pkg::CMD_UP_RD: begin
        re    = !stat.up_done;
        raddr = mv - PW'(1);
      end
      prs_pkg::CMD_UP_WR: begin
        we    = 1'b1;
        waddr = mv - PW'(1) + PW'(d_r);
        wdata = rdv;
      end
      prs_pkg::CMD_DN_RD: begin
        re    = !stat.dn_done;
        raddr = mv;
      end
      prs_pkg::CMD_DN_WR: begin
        we    = 1'b1;
        waddr = mv - PW'(d_r);
        wdata = rdv;
      end
      prs_pkg::CMD_ZERO_WR: begin
        we = !stat.zero_done;
      end
      prs_pkg::CMD_PUT_LEN: begin
        we    = 1'b1;
        waddr = p_r;
        wdata = 8'(wl);
      end
      prs_pkg::CMD_PUT_RD: begin
        buf_re = !stat.put_done;
      end
      prs_pkg::CMD_PUT_WR: begin
        we    = 1'b1;
        waddr = p_r + PW'(i) + PW'(1);
        wdata = bdata;
      end
      prs_pkg::CMD_BASE_WR: begin
        we    = 1'b1;
        waddr = PW'(record_base);
        wdata = count_reg;
      end
      default: begin
      end
    endcase
  end

  // byte store, writes beyond the end are dropped and reads there give zero
  always_ff @(posedge clk) begin
    if (we && waddr < STORE_END) begin
      store[waddr[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata_raw <= store[raddr[AW-1:0]];
      rd_oob    <= (raddr >= STORE_END);
    end
  end

  // word buffer
  always_ff @(posedge clk) begin
    if (acc && item.char_valid && wl < MAX_WL) begin
      wbuf[wl[BW-1:0]] <= item.char_byte;
    end
    if (buf_re) begin
      bdata <= wbuf[i[BW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= 8'd0;
      wl        <= '0;
      pend_op   <= prs_pkg::OP_APPEND;
      pend_idx  <= 8'd0;
      mv        <= '0;
    end else begin
      if (acc) begin
        pend_op  <= prs_pkg::op_t'(item.opcode);
        pend_idx <= item.word_index;
        if (item.char_valid && wl <= MAX_WL) begin
          wl <= wl + WL_W'(1);
        end
      end
      case (cmd)
        prs_pkg::CMD_CLEAR: begin
          mv <= mv + PW'(1);
        end
        prs_pkg::CMD_DECIDE: begin
          if (code == prs_pkg::ST_OK) begin
            case (pend_op)
              prs_pkg::OP_DELETE: begin
                mv        <= p_r + PW'(s_r);
                count_reg <= count_reg - 8'd1;
              end
              prs_pkg::OP_REPLACE: begin
                mv <= stat.need_up ? a : p_r + PW'(s_r);
              end
              prs_pkg::OP_INSERT: begin
                mv        <= a;
                count_reg <= count_reg + 8'd1;
              end
              default: begin
                count_reg <= count_reg + 8'd1;
              end
            endcase
          end
        end
        prs_pkg::CMD_UP_WR: begin
          mv <= mv - PW'(1);
        end
        prs_pkg::CMD_DN_WR: begin
          mv <= mv + PW'(1);
        end
        prs_pkg::CMD_ZERO_INIT: begin
          mv <= lim_r - PW'(d_r);
        end
        prs_pkg::CMD_ZERO_WR: begin
          mv <= mv + PW'(1);
        end
        prs_pkg::CMD_DONE: begin
          wl <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // walk and shift bookkeeping
  always_ff @(posedge clk) begin
    case (cmd)
      prs_pkg::CMD_WALK_INIT: begin
        a <= PW'(record_base) + PW'(1);
        k <= 8'd0;
      end
      prs_pkg::CMD_WALK_RD: begin
        if (k == pend_idx) begin
          p_r <= a;
        end
      end
      prs_pkg::CMD_WALK_ADD: begin
        if (k == pend_idx) begin
          s_r <= 9'(rdv) + 9'd1;
        end
        a <= a + PW'(rdv) + PW'(1);
        k <= k + 8'd1;
      end
      prs_pkg::CMD_DECIDE: begin
        lim_r    <= a;
        status_r <= code;
        case (pend_op)
          prs_pkg::OP_DELETE: begin
            d_r <= s_r;
          end
          prs_pkg::OP_REPLACE: begin
            from_r <= p_r + PW'(s_r);
            d_r    <= stat.need_up ? n9 - s_r : s_r - n9;
          end
          prs_pkg::OP_INSERT: begin
            from_r <= p_r;
            d_r    <= n9;
          end
          default: begin
            p_r <= a;
          end
        endcase
      end
      prs_pkg::CMD_PUT_LEN: begin
        i <= '0;
      end
      prs_pkg::CMD_PUT_WR: begin
        i <= i + WL_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result fields, valid while the controller strobes done
  assign result.status       = status_r;
  assign result.record_count = count_reg;
  assign result.bytes_used   = 11'((a > STORE_END) ? STORE_END : a);

endmodule

// File: design/prs_ctrl.sv
// command sequencer of the record store
module prs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last_char,
  input  prs_pkg::dp_stat_t  stat,
  output prs_pkg::dp_cmd_t   cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [16:0] {
    S_CLEAR  = 17'h00001,
    S_IDLE   = 17'h00002,
    S_WINIT  = 17'h00004,
    S_WRD    = 17'h00008,
    S_WADD   = 17'h00010,
    S_DECIDE = 17'h00020,
    S_UPRD   = 17'h00040,
    S_UPWR   = 17'h00080,
    S_DNRD   = 17'h00100,
    S_DNWR   = 17'h00200,
    S_ZINIT  = 17'h00400,
    S_ZWR    = 17'h00800,
    S_PUTLEN = 17'h01000,
    S_PUTRD  = 17'h02000,
    S_PUTWR  = 17'h04000,
    S_BASE   = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t state, state_next;
  logic   final_walk, final_walk_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // next state and micro-operation
  always_comb begin
    state_next      = state;
    final_walk_next = final_walk;
    cmd             = prs_pkg::CMD_NONE;
    case (state)
      S_CLEAR: begin
        cmd = prs_pkg::CMD_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && last_char) begin
          state_next      = S_WINIT;
          final_walk_next = 1'b0;
        end
      end
      S_WINIT: begin
        cmd        = prs_pkg::CMD_WALK_INIT;
        state_next = S_WRD;
      end
      S_WRD: begin
        cmd = prs_pkg::CMD_WALK_RD;
        if (!stat.walk_done) state_next = S_WADD;
        else if (final_walk) state_next = S_DONE;
        else state_next = S_DECIDE;
      end
      S_WADD: begin
        cmd        = prs_pkg::CMD_WALK_ADD;
        state_next = S_WRD;
      end
      S_DECIDE: begin
        cmd = prs_pkg::CMD_DECIDE;
        if (stat.fail) begin
          state_next      = S_WINIT;
          final_walk_next = 1'b1;
        end else begin
          case (stat.op)
            prs_pkg::OP_DELETE: state_next = S_DNRD;
            prs_pkg::OP_INSERT: state_next = S_UPRD;
            prs_pkg::OP_REPLACE: begin
              if (stat.need_up) state_next = S_UPRD;
              else if (stat.need_dn) state_next = S_DNRD;
              else state_next = S_PUTLEN;
            end
            default: state_next = S_PUTLEN;
          endcase
        end
      end
      S_UPRD: begin
        cmd        = prs_pkg::CMD_UP_RD;
        state_next = stat.up_done ? S_PUTLEN : S_UPWR;
      end
      S_UPWR: begin
        cmd        = prs_pkg::CMD_UP_WR;
        state_next = S_UPRD;
      end
      S_DNRD: begin
        cmd        = prs_pkg::CMD_DN_RD;
        state_next = stat.dn_done ? S_ZINIT : S_DNWR;
      end
      S_DNWR: begin
        cmd        = prs_pkg::CMD_DN_WR;
        state_next = S_DNRD;
      end
      S_ZINIT: begin
        cmd        = prs_pkg::CMD_ZERO_INIT;
        state_next = S_ZWR;
      end
      S_ZWR: begin
        cmd = prs_pkg::CMD_ZERO_WR;
        if (stat.zero_done) begin
          state_next = (stat.op == prs_pkg::OP_DELETE) ? S_BASE : S_PUTLEN;
        end
      end
      S_PUTLEN: begin
        cmd        = prs_pkg::CMD_PUT_LEN;
        state_next = S_PUTRD;
      end
      S_PUTRD: begin
        cmd        = prs_pkg::CMD_PUT_RD;
        state_next = stat.put_done ? S_BASE : S_PUTWR;
      end
      S_PUTWR: begin
        cmd        = prs_pkg::CMD_PUT_WR;
        state_next = S_PUTRD;
      end
      S_BASE: begin
        cmd             = prs_pkg::CMD_BASE_WR;
        state_next      = S_WINIT;
        final_walk_next = 1'b1;
      end
      S_DONE: begin
        cmd        = prs_pkg::CMD_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      final_walk <= 1'b0;
    end else begin
      state      <= state_next;
      final_walk <= final_walk_next;
    end
  end

  // a command transaction always leaves the idle state
  a_cmd_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_char |=> busy)
    else $error("command accepted but block not busy");

  // a result is followed by the idle state
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  // a result only comes from a final walk
  a_done_final: assert property (@(posedge clk) disable iff (rst)
    done |-> final_walk && $past(busy))
    else $error("result without final walk");

endmodule

// File: design/packed_record_store_core.sv
// top level of the packed record store: configuration port and block wiring
//
// After reset the block clears its byte store, one byte a cycle, holding busy
// high until the clear is through. An input transaction without last_char
// leaves the block idle. A command runs on the byte store, one read or write
// at a time: a walk to the end of the list, a shift of the bytes behind the
// record and clearing of freed bytes as needed, writing of the record and of
// the count at record_base, and a second walk. The result is shown for one
// cycle with done and cannot be held off by the receiver. The user writes
// record_base only while busy is low; the block itself does not enforce it.
module packed_record_store_core #(
  parameter int STORE_BYTES    = 1024,
  parameter int MAX_WORD_CHARS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  prs_pkg::item_t   item,
  output logic             done,
  output prs_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [9:0]        record_base;
  prs_pkg::dp_cmd_t  cmd;
  prs_pkg::dp_stat_t stat;

  assign pready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_base <= prs_pkg::BASE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == prs_pkg::REG_RECORD_BASE) begin
      record_base <= pwdata[9:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == prs_pkg::REG_RECORD_BASE) ? {22'd0, record_base} : 32'd0;

  prs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_char (item.last_char),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  prs_datapath #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .record_base (record_base),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

endmodule
